// ----- design/lra_pkg.sv -----
// Shared types and constants for the line resampler.
// Used by the line store, the shared divider and the top level; no dependencies.
`timescale 1ns / 1ps

package lra_pkg;

    // Field widths fixed by the interface.
    localparam int IDX_W  = 12;
    localparam int LEN_W  = 13;
    localparam int PIX_W  = 8;
    localparam int FRAC_W = 8;

    // Derived datapath widths.
    localparam int PROD_W = IDX_W + LEN_W;         // i * src_len
    localparam int NUM_W  = PROD_W + FRAC_W;       // 256 * i * src_len
    localparam int QMAX   = LEN_W + FRAC_W;        // widest quotient
    localparam int QCNT_W = $clog2(QMAX + 1);
    localparam int WT_W   = FRAC_W + 1;            // one pixel weight, up to 256
    localparam int WSUM_W = FRAC_W + LEN_W + 1;    // sum of weights
    localparam int ACC_W  = PIX_W + WSUM_W;        // weighted pixel sum

    localparam logic [WT_W-1:0] FULL_WT = WT_W'(256);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_LEN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DST_LEN = CFG_IDX_W'(1);

    // Request function codes.
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_COMPUTE = 1'b1;

    typedef struct packed {
        logic               start;
        logic [NUM_W-1:0]   dividend;
        logic [WSUM_W-1:0]  divisor;
        logic [QCNT_W-1:0]  qbits;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QMAX-1:0]   quot;
        logic [NUM_W-1:0]  rem;
    } t_div_rsp;

endpackage

// ----- design/lra_line_store.sv -----
// Line store: one synchronous RAM of source pixels, one write and one read port.
// Depends on lra_pkg for the pixel width.
`timescale 1ns / 1ps

module lra_line_store import lra_pkg::*; #(
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [PIX_W-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [PIX_W-1:0] o_rdata
);

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/lra_divider.sv -----
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on lra_pkg for the request and response structs.
`timescale 1ns / 1ps

module lra_divider import lra_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [QCNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_sd;
    logic [QMAX-1:0]   r_quot;
    logic [NUM_W:0]    w_diff;
    logic              w_fits;

    assign w_diff = {1'b0, r_rem} - {1'b0, r_sd};
    assign w_fits = ~w_diff[NUM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == QCNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // The divisor starts aligned under the top quotient bit; the caller
    // guarantees the quotient fits in qbits bits.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.dividend;
            r_sd   <= NUM_W'(i_req.divisor) << (i_req.qbits - QCNT_W'(1));
            r_quot <= '0;
            r_cnt  <= i_req.qbits;
        end else if (r_busy) begin
            if (w_fits) begin
                r_rem <= w_diff[NUM_W-1:0];
            end
            r_quot <= {r_quot[QMAX-2:0], w_fits};
            r_sd   <= r_sd >> 1;
            r_cnt  <= r_cnt - QCNT_W'(1);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

// ----- design/line_resample_average_interp.sv -----
// Line resampler top level: request control, weight sequencing and output register.
// Depends on lra_pkg, lra_line_store and lra_divider.
// A load writes the line store directly; an equal-length or one-pixel-source compute reads one pixel;
// growing runs a 13-step divide, then an 8-step divide unless the position is exact; shrinking
// runs two 21-step divides, one line store read per covered source pixel and an 8-step divide.
// One request is in flight at a time; a finished result waits in the output register.
// Reset (synchronous, active low) sets both lengths to 1, idles the controller and empties
// the output register; the line store is not cleared.
`timescale 1ns / 1ps

module line_resample_average_interp import lra_pkg::*; #(
    parameter int LINE_MAX = 4096,
    localparam int AW = $clog2(LINE_MAX)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_func,
    input  logic [IDX_W-1:0]     i_index,
    input  logic [PIX_W-1:0]     i_pixel,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [IDX_W-1:0]     o_out_index,
    output logic [PIX_W-1:0]     o_out_pixel,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LEN_W-1:0]     i_cfg_data
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'h0001,
        S_SETUP = 13'h0002,
        S_DIV0  = 13'h0004,
        S_DIV1  = 13'h0008,
        S_ACC   = 13'h0010,
        S_ACCW  = 13'h0020,
        S_RD    = 13'h0040,
        S_RDW   = 13'h0080,
        S_GRD0  = 13'h0100,
        S_GRD1  = 13'h0200,
        S_GRD2  = 13'h0400,
        S_DIVF  = 13'h0800,
        S_OUT   = 13'h1000
    } t_state;

    t_state r_state, n_state;

    logic [LEN_W-1:0]  r_src_len, r_dst_len;
    logic              r_go;
    logic              r_rd_pend;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_index;
    logic [PIX_W-1:0]  r_out_pixel;

    logic [IDX_W-1:0]  r_idx;
    logic [LEN_W-1:0]  r_sl, r_dl;
    logic              r_shrink;
    logic [PROD_W-1:0] r_prod;
    logic [LEN_W-1:0]  r_first, r_end, r_addr, r_e;
    logic [WT_W-1:0]   r_w0, r_wt;
    logic [FRAC_W-1:0] r_w1;
    logic [ACC_W-1:0]  r_acc;
    logic [WSUM_W-1:0] r_wsum;
    logic [PIX_W-1:0]  r_pix;

    logic [LEN_W-1:0]        w_src_eff, w_dst_eff, w_sm, w_dm, w_mul_b, w_gwt, w_last;
    logic                    w_in_acc, w_load, w_sl_gt, w_out_load;
    logic [PROD_W-1:0]       w_setup_prod;
    logic [PIX_W-1:0]        w_rdata;
    logic [WT_W-1:0]         w_wt;
    logic [PIX_W+WT_W-1:0]   w_aprod;
    logic [PIX_W+LEN_W-1:0]  w_gprod;
    logic [FRAC_W-1:0]       w_frac;
    t_div_req                w_div_req;
    t_div_rsp                w_div_rsp;

    // Lengths of zero act as 1 and lengths above the store depth act as the depth.
    assign w_src_eff = (r_src_len == '0) ? LEN_W'(1) :
                       (32'(r_src_len) > LINE_MAX) ? LEN_W'(LINE_MAX) : r_src_len;
    assign w_dst_eff = (r_dst_len == '0) ? LEN_W'(1) :
                       (32'(r_dst_len) > LINE_MAX) ? LEN_W'(LINE_MAX) : r_dst_len;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_load      = w_in_acc && (i_func == FUNC_LOAD) && (32'(i_index) < LINE_MAX);

    assign w_sl_gt      = r_sl > r_dl;
    assign w_sm         = r_sl - LEN_W'(1);
    assign w_dm         = r_dl - LEN_W'(1);
    assign w_mul_b      = w_sl_gt ? r_sl : w_sm;
    assign w_setup_prod = r_idx * w_mul_b;

    assign w_last = w_div_rsp.quot[QMAX-1:FRAC_W];
    assign w_frac = w_div_rsp.quot[FRAC_W-1:0];

    // Edge pixels of the covered span take fractional weights, the rest full weight.
    assign w_wt = (r_addr == r_first) ? r_w0 :
                  ((r_addr == r_end) && (r_w1 != '0)) ? {1'b0, r_w1} : FULL_WT;
    assign w_aprod = w_rdata * r_wt;
    assign w_gwt   = (r_state == S_GRD1) ? (w_dm - r_e) : r_e;
    assign w_gprod = w_rdata * w_gwt;

    lra_line_store #(
        .DEPTH(LINE_MAX)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_load),
        .i_waddr(AW'(i_index)),
        .i_wdata(i_pixel),
        .i_raddr(AW'(r_addr)),
        .o_rdata(w_rdata)
    );

    always_comb begin
        w_div_req       = '0;
        w_div_req.start = r_go;
        case (r_state)
            S_DIV0: begin
                if (r_shrink) begin
                    w_div_req.dividend = {r_prod, FRAC_W'(0)};
                    w_div_req.divisor  = WSUM_W'(r_dl);
                    w_div_req.qbits    = QCNT_W'(QMAX);
                end else begin
                    w_div_req.dividend = NUM_W'(r_prod);
                    w_div_req.divisor  = WSUM_W'(w_dm);
                    w_div_req.qbits    = QCNT_W'(LEN_W);
                end
            end
            S_DIV1: begin
                w_div_req.dividend = {r_prod, FRAC_W'(0)};
                w_div_req.divisor  = WSUM_W'(r_dl);
                w_div_req.qbits    = QCNT_W'(QMAX);
            end
            S_DIVF: begin
                w_div_req.dividend = NUM_W'(r_acc);
                w_div_req.divisor  = r_wsum;
                w_div_req.qbits    = QCNT_W'(PIX_W);
            end
            default: ;
        endcase
    end

    lra_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div_req),
        .o_rsp  (w_div_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_func == FUNC_COMPUTE) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                if ({1'b0, r_idx} >= r_dl) begin
                    n_state = S_IDLE;
                end else if (w_sl_gt) begin
                    n_state = S_DIV0;
                end else if (r_sl == r_dl || r_sl == LEN_W'(1)) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_DIV0;
                end
            end
            S_DIV0: begin
                if (w_div_rsp.done) begin
                    if (r_shrink) begin
                        n_state = S_DIV1;
                    end else if (w_div_rsp.rem == '0) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_GRD0;
                    end
                end
            end
            S_DIV1: begin
                if (w_div_rsp.done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (r_addr == r_end) begin
                    n_state = S_ACCW;
                end
            end
            S_ACCW: n_state = S_DIVF;
            S_RD:   n_state = S_RDW;
            S_RDW:  n_state = S_OUT;
            S_GRD0: n_state = S_GRD1;
            S_GRD1: n_state = S_GRD2;
            S_GRD2: n_state = S_DIVF;
            S_DIVF: begin
                if (w_div_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_src_len   <= LEN_W'(1);
            r_dst_len   <= LEN_W'(1);
        end else begin
            r_state   <= n_state;
            // Each divide state is entered at most once per request; start the divider on entry.
            r_go      <= (n_state != r_state) &&
                         (n_state == S_DIV0 || n_state == S_DIV1 || n_state == S_DIVF);
            r_rd_pend <= (r_state == S_ACC);
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_SRC_LEN: r_src_len <= i_cfg_data;
                    REG_DST_LEN: r_dst_len <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_idx <= i_index;
                    r_sl  <= w_src_eff;
                    r_dl  <= w_dst_eff;
                end
            end
            S_SETUP: begin
                r_shrink <= w_sl_gt;
                r_prod   <= w_setup_prod;
                r_addr   <= (r_sl == r_dl) ? LEN_W'(r_idx) : '0;
            end
            S_DIV0: begin
                if (w_div_rsp.done) begin
                    if (r_shrink) begin
                        r_first <= w_last;
                        r_w0    <= FULL_WT - {1'b0, w_frac};
                        r_prod  <= r_prod + PROD_W'(r_sl);
                    end else begin
                        r_addr <= w_div_rsp.quot[LEN_W-1:0];
                        r_e    <= w_div_rsp.rem[LEN_W-1:0];
                    end
                end
            end
            S_DIV1: begin
                if (w_div_rsp.done) begin
                    // A zero far-edge weight drops the last pixel from the span.
                    r_end  <= (w_frac == '0) ? (w_last - LEN_W'(1)) : w_last;
                    r_w1   <= w_frac;
                    r_addr <= r_first;
                    r_acc  <= '0;
                    r_wsum <= '0;
                end
            end
            S_ACC: begin
                r_addr <= r_addr + LEN_W'(1);
                r_wt   <= w_wt;
            end
            S_GRD0: begin
                r_addr <= r_addr + LEN_W'(1);
            end
            S_GRD1: begin
                r_acc  <= ACC_W'(w_gprod);
                r_wsum <= WSUM_W'(w_dm);
            end
            S_GRD2: begin
                r_acc <= r_acc + ACC_W'(w_gprod) + ACC_W'(w_dm >> 1);
            end
            S_RDW: begin
                r_pix <= w_rdata;
            end
            S_DIVF: begin
                if (w_div_rsp.done) begin
                    r_pix <= w_div_rsp.quot[PIX_W-1:0];
                end
            end
            default: ;
        endcase
        if (r_rd_pend) begin
            r_acc  <= r_acc + ACC_W'(w_aprod);
            r_wsum <= r_wsum + WSUM_W'(r_wt);
        end
        if (w_out_load) begin
            r_out_index <= r_idx;
            r_out_pixel <= r_pix;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_index = r_out_index;
    assign o_out_pixel = r_out_pixel;

endmodule

// ----- test/line_resample_average_interp_tb.sv -----
// Self-checking testbench for the line resampler: directed and random load and compute
// requests, checked against an in-bench predictor. Depends on lra_pkg and line_resample_average_interp.
`timescale 1ns / 1ps

module line_resample_average_interp_tb;
    import lra_pkg::*;

    localparam int LINE_MAX = 4096;
    localparam longint unsigned PIX_WEIGHT = 256;
    // Index with no register behind it; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

    typedef enum {FLOW, SEND_GAPS, RECV_STALLS, BOTH_IDLE, LONG_HOLD} idle_mode_t;

    typedef struct {
        logic             func;
        logic [IDX_W-1:0] idx;
        logic [PIX_W-1:0] pix;
    } pix_req_t;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [PIX_W-1:0] pix;
    } pix_out_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 func      = FUNC_LOAD;
    logic [IDX_W-1:0]     idx       = '0;
    logic [PIX_W-1:0]     pix       = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_SRC_LEN;
    logic [LEN_W-1:0]     cfg_data  = '0;

    logic             in_ready;
    logic             out_valid;
    logic [IDX_W-1:0] out_index;
    logic [PIX_W-1:0] out_pixel;
    logic             cfg_ready;

    pix_req_t         req_q[$];
    pix_req_t         cur;
    pix_out_t         pixel_due_q[$];
    logic [PIX_W-1:0] pix_mem [LINE_MAX];
    bit               loaded [LINE_MAX];
    logic [LEN_W-1:0] cfg_src  = LEN_W'(1);
    logic [LEN_W-1:0] cfg_dst  = LEN_W'(1);
    idle_mode_t       run_mode = FLOW;
    int unsigned      err_cnt  = 0;

    line_resample_average_interp #(.LINE_MAX(LINE_MAX)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_func      (func),
        .i_index     (idx),
        .i_pixel     (pix),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_index (out_index),
        .o_out_pixel (out_pixel),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4;
        clk = 1'b1;
        #4;
        clk = 1'b0;
    end

    function automatic int unsigned eff_len(logic [LEN_W-1:0] v);
        if (v == 0) return 1;
        if (v > LINE_MAX) return LINE_MAX;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] resample_pixel(int unsigned i);
        longint unsigned sl, dl, t0, t1, first, last, r0, r1, w, acc, wsum, dm, p, e;
        sl = eff_len(cfg_src);
        dl = eff_len(cfg_dst);
        if (sl == dl) return pix_mem[i];
        if (sl == 1) return pix_mem[0];
        if (sl > dl) begin
            // Area average: partial edge pixels get truncated fractional weights.
            t0 = i * sl;
            first = t0 / dl;
            r0 = t0 % dl;
            w = (r0 == 0) ? PIX_WEIGHT : PIX_WEIGHT - (PIX_WEIGHT * r0) / dl;
            acc = pix_mem[first] * w;
            wsum = w;
            t1 = (i + 1) * sl;
            last = t1 / dl;
            r1 = t1 % dl;
            for (longint unsigned j = first + 1; j < last; j++) begin
                acc += pix_mem[j] * PIX_WEIGHT;
                wsum += PIX_WEIGHT;
            end
            if (r1 != 0) begin
                w = (PIX_WEIGHT * r1) / dl;
                acc += pix_mem[last] * w;
                wsum += w;
            end
            return PIX_W'(acc / wsum);
        end
        dm = dl - 1;
        t0 = i * (sl - 1);
        p = t0 / dm;
        e = t0 % dm;
        if (e == 0) return pix_mem[p];
        return PIX_W'((pix_mem[p] * (dm - e) + pix_mem[p + 1] * e + dm / 2) / dm);
    endfunction

    task automatic queue_load(int unsigned k, int unsigned v);
        req_q.push_back(pix_req_t'{FUNC_LOAD, IDX_W'(k), PIX_W'(v)});
        loaded[k] = 1'b1;
    endtask

    // Loads every source pixel the compute will touch before queuing it, so that no
    // unwritten store entry is ever read. Edge pixels of zero weight are not loaded.
    task automatic queue_compute(int unsigned i);
        longint unsigned sl, dl, lo, hi, t;
        sl = eff_len(cfg_src);
        dl = eff_len(cfg_dst);
        if (i < dl) begin
            if (sl == dl) begin
                lo = i;
                hi = i;
            end else if (sl == 1) begin
                lo = 0;
                hi = 0;
            end else if (sl > dl) begin
                lo = (i * sl) / dl;
                t = (i + 1) * sl;
                hi = (t % dl != 0) ? t / dl : t / dl - 1;
            end else begin
                t = i * (sl - 1);
                lo = t / (dl - 1);
                hi = (t % (dl - 1) != 0) ? lo + 1 : lo;
            end
            for (longint unsigned k = lo; k <= hi; k++) begin
                if (!loaded[k]) queue_load(k, $urandom_range(0, 255));
            end
        end
        req_q.push_back(pix_req_t'{FUNC_COMPUTE, IDX_W'(i), PIX_W'($urandom)});
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] r, logic [LEN_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (r == REG_SRC_LEN) cfg_src = v;
        else if (r == REG_DST_LEN) cfg_dst = v;
    endtask

    // Waits until every request is taken and every result is back, then lets a
    // request that makes no result run out before the block is reconfigured.
    task automatic settle();
        while (req_q.size() != 0 || in_valid || pixel_due_q.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_lengths(logic [LEN_W-1:0] sl, logic [LEN_W-1:0] dl);
        settle();
        write_reg(REG_SRC_LEN, sl);
        write_reg(REG_DST_LEN, dl);
    endtask

    task automatic note_error(string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("ERROR: %s", msg);
    endtask

    // Request driver: the predictor runs as each request is accepted.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                if (cur.func == FUNC_LOAD) begin
                    pix_mem[cur.idx] = cur.pix;
                end else if (cur.idx < eff_len(cfg_dst)) begin
                    pixel_due_q.push_back(pix_out_t'{cur.idx, resample_pixel(cur.idx)});
                end
            end
            if (!in_valid || in_ready) begin
                if (req_q.size() != 0 &&
                    !(run_mode == SEND_GAPS && $urandom_range(0, 99) < 58) &&
                    !(run_mode == BOTH_IDLE && $urandom_range(0, 99) < 16)) begin
                    cur = req_q.pop_front();
                    in_valid <= 1'b1;
                    func     <= cur.func;
                    idx      <= cur.idx;
                    pix      <= cur.pix;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure.
    int unsigned hold_left = 0;
    idle_mode_t  seen_mode = FLOW;

    always @(posedge clk) begin
        pix_out_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (pixel_due_q.size() == 0) begin
                    note_error($sformatf("unexpected result index %0d pixel %0d",
                                         out_index, out_pixel));
                end else begin
                    want = pixel_due_q.pop_front();
                    if (out_index !== want.idx || out_pixel !== want.pix)
                        note_error($sformatf("expected index %0d pixel %0d, got index %0d pixel %0d",
                                             want.idx, want.pix, out_index, out_pixel));
                end
            end
            if (run_mode != seen_mode) begin
                seen_mode = run_mode;
                if (run_mode == LONG_HOLD) hold_left = 500;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= !((run_mode == RECV_STALLS && $urandom_range(0, 99) < 58) ||
                               (run_mode == BOTH_IDLE && $urandom_range(0, 99) < 16));
            end
        end
    end

    initial begin
        int unsigned sl, dl, dle, r;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Lengths at their reset value of one: copy, then indexes past the line.
        queue_load(0, 8'hFF);
        queue_compute(0);
        queue_compute(1);
        queue_compute(LINE_MAX - 1);

        // Oversized source length clamps to the maximum; equal lengths copy.
        set_lengths(LEN_W'(8191), LEN_W'(LINE_MAX));
        queue_load(LINE_MAX - 1, 8'h00);
        queue_compute(LINE_MAX - 1);
        queue_compute(0);

        // Zero source length acts as one pixel, replicated over the whole line.
        set_lengths(LEN_W'(0), LEN_W'(8191));
        queue_compute(LINE_MAX - 1);

        // Two-pixel source grown to the full line, including the rounded midpoint.
        set_lengths(LEN_W'(2), LEN_W'(LINE_MAX));
        queue_load(1, 8'h00);
        queue_compute(0);
        queue_compute(2048);
        queue_compute(LINE_MAX - 1);

        // Slight shrink: fractional edges, and a last pixel whose right edge weight is zero.
        set_lengths(LEN_W'(LINE_MAX), LEN_W'(LINE_MAX - 1));
        queue_compute(0);
        queue_compute(LINE_MAX - 2);

        set_lengths(LEN_W'(5), LEN_W'(3));
        write_reg(REG_SPARE, LEN_W'(8191));
        queue_compute(0);
        queue_compute(1);
        queue_compute(2);

        set_lengths(LEN_W'(3), LEN_W'(5));
        queue_compute(1);
        queue_compute(3);

        set_lengths(LEN_W'(7), LEN_W'(1));
        queue_compute(0);

        for (int ph = 0; ph < 12; ph++) begin
            case ($urandom_range(0, 5))
                0: begin
                    sl = $urandom_range(0, 1);
                    dl = $urandom_range(1, LINE_MAX);
                end
                1: begin
                    sl = $urandom_range(1, LINE_MAX);
                    dl = sl;
                end
                2: begin
                    sl = $urandom_range(2, 64);
                    dl = $urandom_range(sl + 1, 200);
                end
                3: begin
                    sl = $urandom_range(2, 300);
                    dl = $urandom_range(sl + 1, LINE_MAX);
                end
                4: begin
                    dl = $urandom_range(1, 40);
                    sl = $urandom_range(dl + 1, dl * 7);
                end
                default: begin
                    sl = $urandom_range(1000, LINE_MAX);
                    dl = sl - $urandom_range(1, 60);
                end
            endcase
            set_lengths(LEN_W'(sl), LEN_W'(dl));
            run_mode = (ph == 4) ? LONG_HOLD : idle_mode_t'(ph % 4);
            dle = eff_len(cfg_dst);
            for (int k = 0; k < 55; k++) begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    queue_load($urandom_range(0, eff_len(cfg_src) - 1), $urandom_range(0, 255));
                else if (r < 12)
                    queue_load($urandom_range(0, LINE_MAX - 1), $urandom_range(0, 255));
                else if (r < 17)
                    queue_compute($urandom_range(0, LINE_MAX - 1));
                else
                    queue_compute($urandom_range(0, dle - 1));
            end
        end

        settle();
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
